/* sv/pdt_pkg.sv */
package pdt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ACCEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0] kp;
    logic [REG_W-1:0] kd;
    logic [REG_W-1:0] mass;
    logic [REG_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DATA_W:0]   mag;
    logic [DATA_W-1:0] den;
  } div_req_t;

  function automatic logic signed [DATA_W-1:0] sat_s34(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/pdt_div.sv */
module pdt_div #(
  parameter int unsigned FracBits = pdt_pkg::FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdt_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic signed [31:0]       res_o
);

  localparam int unsigned NumW = 33 + FracBits;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]        st_q, st_d;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [31:0]       rem_q, low_q, quo_q, den_q;
  logic              neg_q;
  logic signed [31:0] res_q;

  logic [NumW-1:0]   num;
  logic              over;
  logic [32:0]       trial;
  logic              ge;
  logic [32:0]       diff;
  logic signed [31:0] sat_res;

  assign num   = {req_i.mag, {FracBits{1'b0}}};
  assign over  = {{(64-NumW){1'b0}}, num} >= {req_i.den, 32'd0};
  assign trial = {rem_q, low_q[31]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    if (neg_q) begin
      sat_res = (quo_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - quo_q);
    end else begin
      sat_res = quo_q[31] ? 32'sh7FFF_FFFF : $signed(quo_q);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      D_IDLE: begin
        if (req_i.start) begin
          st_d = ((req_i.den == 32'd0) || over) ? D_FIN : D_RUN;
        end
      end
      D_RUN: begin
        if (cnt_q == 5'd31) begin
          st_d = D_FIN;
        end
      end
      D_FIN:   st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == D_FIN);
      if (st_q == D_RUN) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == D_IDLE && req_i.start) begin
      neg_q <= req_i.neg;
      den_q <= req_i.den;
      rem_q <= {{(31-FracBits){1'b0}}, num[NumW-1:32]};
      low_q <= num[31:0];
      if (req_i.den == 32'd0) begin
        quo_q <= 32'd0;
      end else if (over) begin
        quo_q <= 32'hFFFF_FFFF;
      end else begin
        quo_q <= 32'd0;
      end
    end else if (st_q == D_RUN) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      low_q <= {low_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
    if (st_q == D_FIN) begin
      res_q <= sat_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/pdt_lane.sv */
module pdt_lane #(
  parameter int unsigned FracBits = pdt_pkg::FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  err_i,
  input  logic [31:0]         den_i,
  input  pdt_pkg::cfg_t       cfg_i,
  input  logic [30:0]         grav_i,
  output logic                done_o,
  output logic signed [31:0]  force_o,
  output logic signed [31:0]  pos_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VEL  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_M4   = 4'd5;
  localparam logic [3:0] S_U    = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_M5   = 4'd8;
  localparam logic [3:0] S_M6   = 4'd9;
  localparam logic [3:0] S_M7   = 4'd10;
  localparam logic [3:0] S_M8   = 4'd11;

  logic [3:0]         st_q, st_d;
  logic               done_q;
  logic signed [31:0] prev_q, vel_q, pos_q;
  logic signed [31:0] e_q, v_q, u_q, a_q;
  logic signed [33:0] acc_q;
  logic [63:0]        prod_q;
  logic               pneg_q;

  pdt_pkg::div_req_t  div_req;
  logic               div_done;
  logic signed [31:0] div_res;
  logic signed [32:0] div_val;

  logic signed [31:0] mul_a;
  logic [31:0]        mul_b;
  logic [31:0]        mul_mag;
  logic [63:0]        prod_sh;
  logic signed [31:0] fin;
  logic signed [33:0] fin_x;

  always_comb begin
    if (st_q == S_IDLE) begin
      div_val = {err_i[31], err_i} - {prev_q[31], prev_q};
      div_req.den = den_i;
    end else begin
      div_val = {u_q[31], u_q};
      div_req.den = {1'b0, cfg_i.mass};
    end
    div_req.start = (st_q == S_IDLE && start_i) || (st_q == S_U);
    div_req.neg   = div_val[32];
    div_req.mag   = div_val[32] ? 33'(-div_val) : 33'(div_val);
  end

  pdt_div #(.FracBits(FracBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .res_o  (div_res)
  );

  always_comb begin
    case (st_q)
      S_M1: begin
        mul_a = e_q;
        mul_b = {1'b0, cfg_i.kp};
      end
      S_M2: begin
        mul_a = v_q;
        mul_b = {1'b0, cfg_i.kd};
      end
      S_M3: begin
        mul_a = $signed({1'b0, cfg_i.mass});
        mul_b = {1'b0, grav_i};
      end
      S_M5: begin
        mul_a = a_q;
        mul_b = {1'b0, cfg_i.step};
      end
      S_M7: begin
        mul_a = vel_q;
        mul_b = {1'b0, cfg_i.step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_mag = mul_a[31] ? 32'(-mul_a) : 32'(mul_a);
  assign prod_sh = prod_q >> FracBits;

  always_comb begin
    if (pneg_q) begin
      fin = (prod_sh > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - prod_sh[31:0]);
    end else begin
      fin = (prod_sh > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(prod_sh[31:0]);
    end
  end

  assign fin_x = {{2{fin[31]}}, fin};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (start_i) st_d = S_VEL;
      S_VEL:   if (div_done) st_d = S_M1;
      S_M1:    st_d = S_M2;
      S_M2:    st_d = S_M3;
      S_M3:    st_d = S_M4;
      S_M4:    st_d = S_U;
      S_U:     st_d = S_ACC;
      S_ACC:   if (div_done) st_d = S_M5;
      S_M5:    st_d = S_M6;
      S_M6:    st_d = S_M7;
      S_M7:    st_d = S_M8;
      S_M8:    st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      done_q <= 1'b0;
      prev_q <= '0;
      vel_q  <= '0;
      pos_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == S_M8);
      if (st_q == S_IDLE && start_i) begin
        prev_q <= err_i;
      end
      if (st_q == S_M6) begin
        vel_q <= pdt_pkg::sat_s34({{2{vel_q[31]}}, vel_q} + fin_x);
      end
      if (st_q == S_M8) begin
        pos_q <= pdt_pkg::sat_s34({{2{pos_q[31]}}, pos_q} + fin_x);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_mag) * 64'(mul_b);
    pneg_q <= mul_a[31];
    if (st_q == S_IDLE && start_i) begin
      e_q <= err_i;
    end
    if (st_q == S_VEL && div_done) begin
      v_q <= div_res;
    end
    if (st_q == S_M2) begin
      acc_q <= -fin_x;
    end
    if (st_q == S_M3) begin
      acc_q <= acc_q - fin_x;
    end
    if (st_q == S_M4) begin
      u_q <= pdt_pkg::sat_s34(acc_q + fin_x);
    end
    if (st_q == S_ACC && div_done) begin
      a_q <= pdt_pkg::sat_s34({{2{div_res[31]}}, div_res} - {3'b000, grav_i});
    end
  end

  assign done_o  = done_q;
  assign force_o = u_q;
  assign pos_o   = pos_q;

endmodule

/* sv/pd_tracker_with_euler_plant_unit.sv */
// Each axis lane runs two 32-step restoring divisions per item; a division whose quotient
// overflows 32 bits or whose divisor is zero skips those steps and goes straight to its end.
// The block holds one item at a time: the next input beat is taken only once the result
// has moved into the output register. Reset (asynchronous, active low) loads the register
// defaults, clears the follower state and the previous errors, and marks the next item first.
module pd_tracker_with_euler_plant_unit #(
  parameter int unsigned FracBits = pdt_pkg::FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // error_x [31:0], error_y [63:32], elapsed_time [95:64]
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // force_x [31:0], force_y [63:32], follower_x [95:64], follower_y [127:96]
  output logic [127:0] m_axis_tdata_o,
  // zero_time_fault [0]
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [pdt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [63:0] OneQ     = 64'd1 << FracBits;
  localparam logic [30:0] KpRst    = 31'((OneQ * 64'd5 + 64'd50) / 64'd100);
  localparam logic [30:0] MassRst  = 31'(OneQ * 64'd5);
  localparam logic [30:0] GravRst  = 31'((OneQ * 64'd981 + 64'd50) / 64'd100);
  localparam logic [30:0] StepRst  = 31'(OneQ);

  logic [30:0] kp_q, kd_q, mass_q, grav_q, step_q;
  logic        first_q, busy_q, fault_q, xd_q, yd_q, m_valid_q;
  logic [127:0] out_data_q;
  logic        out_user_q;

  logic        s_hs, merge;
  logic [31:0] elapsed, den;
  pdt_pkg::cfg_t cfg;

  logic               x_done, y_done;
  logic signed [31:0] x_force, y_force, x_pos, y_pos;

  assign s_axis_tready_o = !busy_q;
  assign cfg_ready_o     = 1'b1;
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign elapsed         = s_axis_tdata_i[95:64];
  assign den             = first_q ? {1'b0, step_q} : elapsed;
  assign merge           = busy_q && xd_q && yd_q && (!m_valid_q || m_axis_tready_i);

  assign cfg.kp   = kp_q;
  assign cfg.kd   = kd_q;
  assign cfg.mass = mass_q;
  assign cfg.step = step_q;

  pdt_lane #(.FracBits(FracBits)) u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_hs),
    .err_i   ($signed(s_axis_tdata_i[31:0])),
    .den_i   (den),
    .cfg_i   (cfg),
    .grav_i  (31'd0),
    .done_o  (x_done),
    .force_o (x_force),
    .pos_o   (x_pos)
  );

  pdt_lane #(.FracBits(FracBits)) u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_hs),
    .err_i   ($signed(s_axis_tdata_i[63:32])),
    .den_i   (den),
    .cfg_i   (cfg),
    .grav_i  (grav_q),
    .done_o  (y_done),
    .force_o (y_force),
    .pos_o   (y_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= KpRst;
      kd_q      <= KpRst;
      mass_q    <= MassRst;
      grav_q    <= GravRst;
      step_q    <= StepRst;
      first_q   <= 1'b1;
      busy_q    <= 1'b0;
      fault_q   <= 1'b0;
      xd_q      <= 1'b0;
      yd_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pdt_pkg::REG_KP_GAIN:       kp_q   <= cfg_data_i[30:0];
          pdt_pkg::REG_KD_GAIN:       kd_q   <= cfg_data_i[30:0];
          pdt_pkg::REG_BODY_MASS:     mass_q <= cfg_data_i[30:0];
          pdt_pkg::REG_GRAVITY_ACCEL: grav_q <= cfg_data_i[30:0];
          pdt_pkg::REG_STEP_TIME:     step_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_hs) begin
        first_q <= 1'b0;
        busy_q  <= 1'b1;
        fault_q <= !first_q && (elapsed == 32'd0);
      end else if (merge) begin
        busy_q <= 1'b0;
      end
      if (merge) begin
        xd_q <= 1'b0;
        yd_q <= 1'b0;
      end else begin
        if (x_done) xd_q <= 1'b1;
        if (y_done) yd_q <= 1'b1;
      end
      if (merge) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge) begin
      out_data_q <= {y_pos, x_pos, y_force, x_force};
      out_user_q <= fault_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

/* sv/pdt_checker.sv */
module pdt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  logic s_hs;
  assign s_hs = s_axis_tvalid_i && s_axis_tready_o;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared one cycle after the input beat");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> m_axis_tvalid_o)
    else $error("block freed without presenting a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind pd_tracker_with_euler_plant_unit pdt_checker u_pdt_checker (.*);
